[design/sha1_pkg.sv]
// shared types, constants and round functions for the sha-1 core
package sha1_pkg;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [7:0] PAD_BYTE  = 8'h80;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  typedef enum logic [1:0] {
    SEL_INPUT,
    SEL_ONE,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      push;
    byte_sel_t byte_sel;
    logic      round;
    logic [1:0] phase;
    logic      add;
    logic      shift_out;
    logic      init;
  } sha1_cmd_t;

  function automatic logic [31:0] round_k(input logic [1:0] phase);
    logic [31:0] k;
    case (phase)
      2'd0:    k = 32'h5a827999;
      2'd1:    k = 32'h6ed9eba1;
      2'd2:    k = 32'h8f1bbcdc;
      default: k = 32'hca62c1d6;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] phase, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (phase)
      2'd0:    f = (b & c) | (~b & d);
      2'd2:    f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

[design/sha1_ctrl.sv]
// sequencer for byte intake, padding, the 80 rounds and digest output
module sha1_ctrl
  import sha1_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       in_op,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [2:0] word_number,
  output logic       last_word,
  output sha1_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD_ONE,
    S_PAD_ZERO,
    S_PAD_LEN,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_t;

  state_t     state_r, state_nxt, ret_r, ret_nxt, tgt;
  logic [5:0] fill_r, fill_nxt;
  logic [4:0] rnd_r, rnd_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [2:0] wcnt_r, wcnt_nxt;

  assign in_tready   = (state_r == S_IDLE);
  assign out_tvalid  = (state_r == S_OUT);
  assign word_number = wcnt_r;
  assign last_word   = (wcnt_r == 3'd4);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    fill_nxt  = fill_r;
    rnd_nxt   = rnd_r;
    phase_nxt = phase_r;
    wcnt_nxt  = wcnt_r;
    tgt       = state_r;
    cmd       = '0;
    cmd.phase = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_op == OP_FINISH) begin
            state_nxt = S_PAD_ONE;
          end else begin
            cmd.push     = 1'b1;
            cmd.byte_sel = SEL_INPUT;
            tgt          = S_IDLE;
          end
        end
      end
      S_PAD_ONE: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = SEL_ONE;
        tgt          = S_PAD_ZERO;
        state_nxt    = S_PAD_ZERO;
      end
      S_PAD_ZERO: begin
        if (fill_r == LEN_POS) begin
          state_nxt = S_PAD_LEN;
        end else begin
          cmd.push     = 1'b1;
          cmd.byte_sel = SEL_ZERO;
          tgt          = S_PAD_ZERO;
        end
      end
      S_PAD_LEN: begin
        // the eighth length byte always completes the block
        cmd.push     = 1'b1;
        cmd.byte_sel = SEL_LEN;
        tgt          = S_OUT;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (rnd_r == 5'd19) begin
          rnd_nxt = '0;
          if (phase_r == 2'd3) begin
            state_nxt = S_ADD;
          end else begin
            phase_nxt = phase_r + 2'd1;
          end
        end else begin
          rnd_nxt = rnd_r + 5'd1;
        end
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ret_r;
      end
      S_OUT: begin
        if (out_tready) begin
          cmd.shift_out = 1'b1;
          if (wcnt_r == 3'd4) begin
            cmd.init  = 1'b1;
            wcnt_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            wcnt_nxt = wcnt_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a full block diverts to compression, then resumes at tgt
    if (cmd.push) begin
      fill_nxt = fill_r + 6'd1;
      if (fill_r == LAST_BYTE) begin
        ret_nxt   = tgt;
        state_nxt = S_ROUND;
        rnd_nxt   = '0;
        phase_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      fill_r  <= '0;
      rnd_r   <= '0;
      phase_r <= '0;
      wcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      fill_r  <= fill_nxt;
      rnd_r   <= rnd_nxt;
      phase_r <= phase_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

endmodule

[design/sha1_datapath.sv]
// block buffer with message schedule, round unit, chaining words and length counter
module sha1_datapath
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sha1_cmd_t   cmd,
  input  logic [7:0]  data_byte,
  output logic [31:0] digest_word
);

  logic [511:0] msg_r;
  logic [60:0]  len_r;
  logic [31:0]  chain_r [5];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [7:0]   push_byte;
  logic [31:0]  w_cur, w_new, tmp;

  always_comb begin
    case (cmd.byte_sel)
      SEL_INPUT: push_byte = data_byte;
      SEL_ONE:   push_byte = PAD_BYTE;
      SEL_ZERO:  push_byte = 8'h00;
      default:   push_byte = len_r[60:53];
    endcase
  end

  // schedule window: oldest word at the top, next word enters at the bottom
  assign w_cur = msg_r[511:480];
  always_comb begin
    w_new = msg_r[95:64] ^ msg_r[255:224] ^ msg_r[447:416] ^ msg_r[511:480];
    w_new = {w_new[30:0], w_new[31]};
  end

  assign tmp = {a_r[26:0], a_r[31:27]} + round_f(cmd.phase, b_r, c_r, d_r) + e_r
               + round_k(cmd.phase) + w_cur;

  assign digest_word = chain_r[0];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      msg_r <= {msg_r[503:0], push_byte};
    end else if (cmd.round) begin
      msg_r <= {msg_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (cmd.round) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cmd.init) begin
      len_r <= '0;
    end else if (cmd.push && cmd.byte_sel == SEL_INPUT) begin
      len_r <= len_r + 61'd1;
    end else if (cmd.push && cmd.byte_sel == SEL_LEN) begin
      // byte count seen as a 64-bit bit count, top byte leaves first
      len_r <= {len_r[52:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      chain_r[0] <= IV0;
      chain_r[1] <= IV1;
      chain_r[2] <= IV2;
      chain_r[3] <= IV3;
      chain_r[4] <= IV4;
    end else if (cmd.add) begin
      chain_r[0] <= chain_r[0] + a_r;
      chain_r[1] <= chain_r[1] + b_r;
      chain_r[2] <= chain_r[2] + c_r;
      chain_r[3] <= chain_r[3] + d_r;
      chain_r[4] <= chain_r[4] + e_r;
    end else if (cmd.shift_out) begin
      chain_r[0] <= chain_r[1];
      chain_r[1] <= chain_r[2];
      chain_r[2] <= chain_r[3];
      chain_r[3] <= chain_r[4];
      chain_r[4] <= chain_r[0];
    end
  end

endmodule

[design/sha1_message_digest_core.sv]
// sha-1 core top level: byte stream in, five digest words out
//
//  channel | dir | tdata                                   | tuser      | tlast
//  in_     | in  | [7:0] data_byte                         | operation  | -
//  out_    | out | [31:0] digest_word, [34:32] word_number | -          | last_word
//
// an absorb word is taken while idle; every 64th byte diverts to compression (80 rounds,
// one per cycle in the round unit, then the chaining add); no byte is taken meanwhile
// a finish word is followed by the pad byte, zero bytes, a pause before the length bytes
// and one or two compressions, then presents the five digest words, one per accepted word
// synchronous active-low reset loads the initial chaining values and clears counts
// in_tready is high only while idle; output stalls hold the digest
module sha1_message_digest_core
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_number
  output logic        out_tlast
);

  sha1_cmd_t   cmd;
  logic [2:0]  word_number;
  logic [31:0] digest_word;

  sha1_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_op       (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .word_number (word_number),
    .last_word   (out_tlast),
    .cmd         (cmd)
  );

  sha1_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_tdata),
    .digest_word (digest_word)
  );

  assign out_tdata = {5'b00000, word_number, digest_word};

endmodule

[sim/sha1_message_digest_core_test.sv]
// self-checking testbench for the sha-1 core: random byte messages, digest words checked
module sha1_message_digest_core_test;
  import sha1_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 250;
  localparam int NUM_ITEMS   = 270;

  localparam logic [31:0] K_CH  = 32'h5a827999;
  localparam logic [31:0] K_PAR = 32'h6ed9eba1;
  localparam logic [31:0] K_MAJ = 32'h8f1bbcdc;
  localparam logic [31:0] K_END = 32'hca62c1d6;

  typedef struct {
    logic       op;
    logic [7:0] data;
    bit         drain;   // hold this word back until every digest word is in
  } byte_word_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  num;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] data_byte
  logic        in_tuser = 1'b0; // [0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [31:0] digest_word, [34:32] word_number
  logic        out_tlast;

  byte_word_t   pending_bytes[$];
  digest_word_t digest_q[$];

  // own copy of the hash state
  logic [31:0] h_chain[5];
  logic [7:0]  h_block[64];
  logic [5:0]  h_fill;
  logic [60:0] h_len;

  int unsigned digests_predicted = 0;
  int unsigned digests_seen = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          in_calm = 0;
  int          out_calm = 0;

  sha1_message_digest_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  function automatic void hash_init();
    h_chain[0] = IV0;
    h_chain[1] = IV1;
    h_chain[2] = IV2;
    h_chain[3] = IV3;
    h_chain[4] = IV4;
    foreach (h_block[i]) h_block[i] = '0;
    h_fill = '0;
    h_len = '0;
  endfunction

  function automatic void hash_block();
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++)
      w[i] = {h_block[4*i], h_block[4*i+1], h_block[4*i+2], h_block[4*i+3]};
    for (int i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = h_chain[0]; b = h_chain[1]; c = h_chain[2]; d = h_chain[3]; e = h_chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K_PAR;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_END;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    h_chain[0] += a; h_chain[1] += b; h_chain[2] += c; h_chain[3] += d; h_chain[4] += e;
  endfunction

  function automatic void hash_put(input logic [7:0] v);
    h_block[h_fill] = v;
    h_fill = h_fill + 6'd1;
    if (h_fill == 6'd0) hash_block();
  endfunction

  // absorb a byte, or pad and queue the five digest words
  function automatic void hash_word(input logic op, input logic [7:0] v);
    logic [63:0]  bit_len;
    digest_word_t dw;
    if (op == OP_ABSORB) begin
      h_len = h_len + 61'd1;
      hash_put(v);
    end else begin
      bit_len = {h_len, 3'b000};
      hash_put(PAD_BYTE);
      while (h_fill != LEN_POS) hash_put(8'h00);
      for (int i = 0; i < 8; i++) hash_put(bit_len[63 - 8*i -: 8]);
      for (int i = 0; i < 5; i++) begin
        dw.word = h_chain[i];
        dw.num = 3'(i);
        dw.last = (i == 4);
        digest_q.insert(digest_q.size(), dw);
      end
      digests_predicted += 5;
      hash_init();
    end
  endfunction

  // mostly short gaps, a few long ones, and calm stretches with none
  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_word(input logic op, input logic [7:0] v, input bit drain);
    byte_word_t bw;
    bw.op = op;
    bw.data = v;
    bw.drain = drain;
    pending_bytes.insert(pending_bytes.size(), bw);
  endtask

  task automatic queue_message(input int len, input bit drain);
    int fill_mode;
    logic [7:0] v;
    fill_mode = $urandom_range(0, 9);
    for (int i = 0; i < len; i++) begin
      case (fill_mode)
        0:       v = 8'h00;
        1:       v = 8'hff;
        default: v = 8'($urandom());
      endcase
      queue_word(OP_ABSORB, v, drain && i == 0);
    end
    queue_word(OP_FINISH, 8'($urandom()), drain && len == 0);
  endtask

  // driver
  always @(posedge clk) begin
    byte_word_t bw;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) hash_word(in_tuser, in_tdata);
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0 &&
                     !(pending_bytes[0].drain && digests_predicted != digests_seen)) begin
          bw = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= bw.op;
          in_tdata <= bw.data;
          in_gap <= draw_gap(in_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    digest_word_t dw;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        digests_seen <= digests_seen + 1;
        if (digest_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: digest %h number %0d last %b",
                     out_tdata[31:0], out_tdata[34:32], out_tlast);
        end else begin
          dw = digest_q.pop_front();
          if (out_tdata[31:0] !== dw.word || out_tdata[34:32] !== dw.num ||
              out_tlast !== dw.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %h/%0d/%b got %h/%0d/%b",
                       dw.word, dw.num, dw.last,
                       out_tdata[31:0], out_tdata[34:32], out_tlast);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && out_tready) out_gap <= draw_gap(out_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int total;
    int r;
    int len;
    hash_init();

    // empty message, with a nonzero byte on the finish word
    queue_word(OP_FINISH, 8'hff, 1'b0);
    queue_word(OP_ABSORB, 8'h61, 1'b0);
    queue_word(OP_ABSORB, 8'h62, 1'b0);
    queue_word(OP_ABSORB, 8'h63, 1'b0);
    queue_word(OP_FINISH, 8'h00, 1'b0);
    queue_word(OP_ABSORB, 8'h00, 1'b1);
    queue_word(OP_FINISH, 8'haa, 1'b0);
    queue_word(OP_ABSORB, 8'hff, 1'b0);
    queue_word(OP_FINISH, 8'h55, 1'b0);
    queue_word(OP_FINISH, 8'h00, 1'b0);

    // lengths are mostly short, else cluster around the one-block and two-block padding edges
    total = pending_bytes.size();
    while (total < NUM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 55) len = $urandom_range(0, 12);
      else if (r < 85) len = $urandom_range(53, 66);
      else len = $urandom_range(117, 130);
      if (len > NUM_ITEMS - 1 - total) len = NUM_ITEMS - 1 - total;
      queue_message(len, total == pending_bytes.size() || $urandom_range(0, 5) == 0);
      total += len + 1;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // sample between edges so every update of the last edge has landed
    while (pending_bytes.size() > 0 || in_tvalid) @(negedge clk);
    @(negedge clk);
    while (digests_predicted != digests_seen) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    errors += digest_q.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
